// ===== rtl/spf_pkg.sv =====
// Shared types and constants of the smallest-prime-factor sieve and factorizer.
`timescale 1ns / 1ps

package spf_pkg;

	// Field widths of the input and result items.
	localparam int ValueW   = 16;
	localparam int ExpW     = 5;
	localparam int StatusW  = 2;
	localparam int EntryW   = 16;
	localparam int DataW    = 24;

	// Values above 65535 never reach the table, so storage stops there.
	localparam int MaxTable     = 65536;
	localparam int TableSizeDef = 65536;

	// Result status codes.
	typedef enum logic [StatusW-1:0] {
		ST_FACTOR  = 2'd0,
		ST_ONE     = 2'd1,
		ST_INVALID = 2'd2,
		ST_BUILT   = 2'd3
	} status_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic    load_x;
		logic    init_start;
		logic    init_wr;
		logic    i_start;
		logic    i_next;
		logic    rd_i;
		logic    j_start;
		logic    j_next;
		logic    rd_j;
		logic    wr_j;
		logic    rd_x;
		logic    take_p;
		logic    clr_e;
		logic    div_start;
		logic    out_load;
		logic    out_last;
		status_t out_status;
	} spf_cmd_t;

	// Status from the datapath back to the controller.
	typedef struct packed {
		logic mode;
		logic in_zero;
		logic in_one;
		logic in_big;
		logic init_last;
		logic sq_end;
		logic rd_eq_i;
		logic j_end;
		logic rd_eq_j;
		logic rd_eq_p;
		logic e_zero;
		logic div_done;
		logic x_one;
		logic out_free;
	} spf_sts_t;

endpackage

// ===== rtl/spf_sieve_factorizer_core.sv =====
// Top level of the smallest-prime-factor sieve and factorizer.
// Usage:
//   Input items arrive on the s_ channel: s_tuser selects the operation (0 builds the
//   factor table, 1 factors s_tdata). Results leave on the m_ channel: m_tdata carries
//   the prime and its exponent, m_tuser the status, m_tlast marks the final result.
//   One item is worked on at a time; s_tready is high only while the block is idle.
//   A build writes every table entry once, then sieves odd primes below the square root
//   of the table depth, marking each multiple from the square on that is still unmarked,
//   then returns one result. Factoring runs a table read, the divider steps and its
//   done, and bookkeeping for each prime factor counted with multiplicity; each change
//   of prime adds an emit step that loads the result of the previous prime.
//   Zero, out-of-range values, and factor items before any build give one error result.
//   After reset the table is marked unbuilt; its contents are undefined until a build.
//   A stalled receiver holds the result register; the walk waits until it frees, and
//   a new item may be accepted while the last result of the previous one still waits.
`timescale 1ns / 1ps

module spf_sieve_factorizer_core import spf_pkg::*; #(
	parameter int TABLE_SIZE = TableSizeDef
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [ValueW-1:0]  s_tdata,   // [15:0] value
	input  logic               s_tuser,   // [0] mode
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [DataW-1:0]   m_tdata,   // [15:0] prime, [20:16] exponent, [23:21] zero
	output logic [StatusW-1:0] m_tuser,   // [1:0] status
	output logic               m_tlast
);

	spf_cmd_t cmd;
	spf_sts_t sts;

	spf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	spf_dp #(
		.TABLE_SIZE (TABLE_SIZE)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.sts      (sts),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

endmodule

// ===== rtl/spf_div.sv =====
// Iterative 16-bit unsigned divider, two quotient bits per cycle.
`timescale 1ns / 1ps

module spf_div import spf_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [ValueW-1:0] dividend,
	input  logic [ValueW-1:0] divisor,
	output logic              done,
	output logic [ValueW-1:0] quotient
);

	localparam int StepsPerCycle = 2;
	localparam int Cycles        = ValueW / StepsPerCycle;
	localparam int CntW          = $clog2(Cycles);
	localparam logic [CntW-1:0] LastCnt = CntW'(Cycles - 1);

	logic              busy_q;
	logic              done_q;
	logic [CntW-1:0]   cnt_q;
	logic [ValueW-1:0] rem_q;
	logic [ValueW-1:0] quo_q;
	logic [ValueW-1:0] den_q;
	logic [ValueW-1:0] rem1;
	logic [ValueW-1:0] quo1;
	logic [ValueW-1:0] rem2;
	logic [ValueW-1:0] quo2;

	// One restoring step: shift in the next dividend bit, subtract if it fits.
	function automatic logic [2*ValueW-1:0] div_step(input logic [ValueW-1:0] rem,
			input logic [ValueW-1:0] quo, input logic [ValueW-1:0] den);
		logic [ValueW:0]   sh;
		logic [ValueW:0]   diff;
		logic [ValueW-1:0] rem_n;
		logic              qbit;
		sh   = {rem, quo[ValueW-1]};
		diff = sh - {1'b0, den};
		if (sh >= {1'b0, den}) begin
			rem_n = diff[ValueW-1:0];
			qbit  = 1'b1;
		end else begin
			rem_n = sh[ValueW-1:0];
			qbit  = 1'b0;
		end
		return {rem_n, quo[ValueW-2:0], qbit};
	endfunction

	// Two steps per cycle.
	always_comb begin
		{rem1, quo1} = div_step(rem_q, quo_q, den_q);
		{rem2, quo2} = div_step(rem1, quo1, den_q);
	end

	// Sequencing of the divider.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= busy_q && (cnt_q == LastCnt);
			if (start) begin
				busy_q <= 1'b1;
			end else if (busy_q && (cnt_q == LastCnt)) begin
				busy_q <= 1'b0;
			end
		end
	end

	// Partial remainder and quotient.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			den_q <= divisor;
			cnt_q <= '0;
		end else if (busy_q) begin
			rem_q <= rem2;
			quo_q <= quo2;
			cnt_q <= cnt_q + CntW'(1);
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

// ===== rtl/spf_dp.sv =====
// Datapath: factor table memory, sieve counters, factoring registers and result register.
`timescale 1ns / 1ps

module spf_dp import spf_pkg::*; #(
	parameter int TABLE_SIZE = TableSizeDef
) (
	input  logic               clk,
	input  logic               arst_n,
	input  spf_cmd_t           cmd,
	output spf_sts_t           sts,
	input  logic [ValueW-1:0]  s_tdata,
	input  logic               s_tuser,
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [DataW-1:0]   m_tdata,
	output logic [StatusW-1:0] m_tuser,
	output logic               m_tlast
);

	localparam int MemDepth = (TABLE_SIZE < MaxTable) ? TABLE_SIZE : MaxTable;
	localparam int MemAw    = $clog2(MemDepth);
	localparam int CntW     = MemAw + 3;
	localparam int PadW     = DataW - ValueW - ExpW;
	localparam logic [CntW-1:0]  DepthC  = CntW'(MemDepth);
	localparam logic [MemAw-1:0] LastIdx = MemAw'(MemDepth - 1);

	logic [EntryW-1:0] mem [MemDepth];
	logic [EntryW-1:0] rd_q;
	logic              rd_en;
	logic [MemAw-1:0]  rd_addr;
	logic [EntryW-1:0] init_val;
	logic [MemAw-1:0]  c_q;
	logic [CntW-1:0]   i_q;
	logic [CntW-1:0]   sq_q;
	logic [CntW-1:0]   j_q;
	logic [ValueW-1:0] x_q;
	logic [ValueW-1:0] p_q;
	logic [ExpW-1:0]   e_q;
	logic              div_done;
	logic [ValueW-1:0] quotient;
	logic              m_valid_q;
	logic [ValueW-1:0] prime_q;
	logic [ExpW-1:0]   exp_q;
	logic              last_q;
	status_t           status_q;

	// Starting table contents: 0, 1, then odd numbers point to themselves, even ones to 2.
	always_comb begin
		if (c_q == '0) begin
			init_val = '0;
		end else if (c_q == MemAw'(1)) begin
			init_val = EntryW'(1);
		end else if (c_q[0]) begin
			init_val = EntryW'(c_q);
		end else begin
			init_val = EntryW'(2);
		end
	end

	// Read address selection.
	always_comb begin
		rd_en = cmd.rd_i | cmd.rd_j | cmd.rd_x;
		if (cmd.rd_x) begin
			rd_addr = x_q[MemAw-1:0];
		end else if (cmd.rd_j) begin
			rd_addr = j_q[MemAw-1:0];
		end else begin
			rd_addr = i_q[MemAw-1:0];
		end
	end

	// Factor table: one write and one registered read per cycle.
	always_ff @(posedge clk) begin
		if (cmd.init_wr) begin
			mem[c_q] <= init_val;
		end else if (cmd.wr_j) begin
			mem[j_q[MemAw-1:0]] <= EntryW'(i_q);
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	// Sieve counters: fill index, candidate prime with its square, and multiple.
	always_ff @(posedge clk) begin
		if (cmd.init_start) begin
			c_q <= '0;
		end else if (cmd.init_wr) begin
			c_q <= c_q + MemAw'(1);
		end
		if (cmd.i_start) begin
			i_q  <= CntW'(3);
			sq_q <= CntW'(9);
		end else if (cmd.i_next) begin
			i_q  <= i_q + CntW'(2);
			sq_q <= sq_q + (i_q << 2) + CntW'(4);
		end
		if (cmd.j_start) begin
			j_q <= sq_q;
		end else if (cmd.j_next) begin
			j_q <= j_q + i_q;
		end
	end

	// Factoring registers: remaining value, current prime, its exponent.
	always_ff @(posedge clk) begin
		if (cmd.load_x) begin
			x_q <= s_tdata;
		end else if (div_done) begin
			x_q <= quotient;
		end
		if (cmd.take_p) begin
			p_q <= rd_q;
		end
		if (cmd.load_x || cmd.clr_e) begin
			e_q <= '0;
		end else if (div_done) begin
			e_q <= e_q + ExpW'(1);
		end
	end

	spf_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (x_q),
		.divisor  (rd_q),
		.done     (div_done),
		.quotient (quotient)
	);

	// Result register, freed when the receiver takes the item.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			prime_q  <= (cmd.out_status == ST_FACTOR) ? p_q : '0;
			exp_q    <= (cmd.out_status == ST_FACTOR) ? e_q : '0;
			last_q   <= cmd.out_last;
			status_q <= cmd.out_status;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {{PadW{1'b0}}, exp_q, prime_q};
	assign m_tuser  = status_q;
	assign m_tlast  = last_q;

	// Status toward the controller.
	always_comb begin
		sts.mode      = s_tuser;
		sts.in_zero   = (s_tdata == '0);
		sts.in_one    = (s_tdata == ValueW'(1));
		sts.in_big    = ({16'b0, s_tdata} >= 32'(TABLE_SIZE));
		sts.init_last = (c_q == LastIdx);
		sts.sq_end    = (sq_q >= DepthC);
		sts.rd_eq_i   = (32'(rd_q) == 32'(i_q));
		sts.j_end     = (j_q >= DepthC);
		sts.rd_eq_j   = (32'(rd_q) == 32'(j_q));
		sts.rd_eq_p   = (rd_q == p_q);
		sts.e_zero    = (e_q == '0);
		sts.div_done  = div_done;
		sts.x_one     = (x_q == ValueW'(1));
		sts.out_free  = !m_valid_q || m_tready;
	end

	// A division always uses a prime read from the table.
	a_div_prime: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start |-> (rd_q >= EntryW'(2)))
		else $error("division started with a divisor below two");

	// Factoring reads stay inside the built table.
	a_read_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rd_x |-> (x_q >= ValueW'(2) && 32'(x_q) < 32'(MemDepth)))
		else $error("factoring read outside the table");

	// A result is only loaded into a free result register.
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> sts.out_free)
		else $error("result register overwritten");

	// Every factor result carries a nonzero exponent.
	a_exp_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.out_load && cmd.out_status == ST_FACTOR) |-> (e_q != '0))
		else $error("factor result with zero exponent");

endmodule

// ===== rtl/spf_ctrl.sv =====
// Controller state machine for the table build and the factoring walk.
`timescale 1ns / 1ps

module spf_ctrl import spf_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     s_tvalid,
	output logic     s_tready,
	input  spf_sts_t sts,
	output spf_cmd_t cmd
);

	typedef enum logic [11:0] {
		S_IDLE   = 12'b0000_0000_0001,
		S_ONE    = 12'b0000_0000_0010,
		B_INIT   = 12'b0000_0000_0100,
		B_NEXT_I = 12'b0000_0000_1000,
		B_CHK_I  = 12'b0000_0001_0000,
		B_RD_J   = 12'b0000_0010_0000,
		B_CHK_J  = 12'b0000_0100_0000,
		F_RD     = 12'b0000_1000_0000,
		F_WAIT   = 12'b0001_0000_0000,
		F_EMIT   = 12'b0010_0000_0000,
		F_DIV    = 12'b0100_0000_0000,
		F_CHK    = 12'b1000_0000_0000
	} state_t;

	state_t  state_q;
	state_t  state_d;
	status_t res_st_q;
	status_t res_st_d;
	logic    built_q;
	logic    built_d;

	// Next state and command decode.
	always_comb begin
		cmd      = '0;
		state_d  = state_q;
		res_st_d = res_st_q;
		built_d  = built_q;
		s_tready = (state_q == S_IDLE);
		unique case (state_q)
			S_IDLE: begin
				if (s_tvalid) begin
					if (!sts.mode) begin
						cmd.init_start = 1'b1;
						state_d        = B_INIT;
					end else if (!built_q || sts.in_zero || sts.in_big) begin
						res_st_d = ST_INVALID;
						state_d  = S_ONE;
					end else if (sts.in_one) begin
						res_st_d = ST_ONE;
						state_d  = S_ONE;
					end else begin
						cmd.load_x = 1'b1;
						state_d    = F_RD;
					end
				end
			end
			B_INIT: begin
				cmd.init_wr = 1'b1;
				if (sts.init_last) begin
					cmd.i_start = 1'b1;
					state_d     = B_NEXT_I;
				end
			end
			B_NEXT_I: begin
				if (sts.sq_end) begin
					built_d  = 1'b1;
					res_st_d = ST_BUILT;
					state_d  = S_ONE;
				end else begin
					cmd.rd_i = 1'b1;
					state_d  = B_CHK_I;
				end
			end
			B_CHK_I: begin
				if (sts.rd_eq_i) begin
					cmd.j_start = 1'b1;
					state_d     = B_RD_J;
				end else begin
					cmd.i_next = 1'b1;
					state_d    = B_NEXT_I;
				end
			end
			B_RD_J: begin
				if (sts.j_end) begin
					cmd.i_next = 1'b1;
					state_d    = B_NEXT_I;
				end else begin
					cmd.rd_j = 1'b1;
					state_d  = B_CHK_J;
				end
			end
			B_CHK_J: begin
				cmd.wr_j   = sts.rd_eq_j;
				cmd.j_next = 1'b1;
				state_d    = B_RD_J;
			end
			F_RD: begin
				cmd.rd_x = 1'b1;
				state_d  = F_WAIT;
			end
			F_WAIT: begin
				if (!sts.e_zero && !sts.rd_eq_p) begin
					state_d = F_EMIT;
				end else begin
					cmd.take_p    = 1'b1;
					cmd.div_start = 1'b1;
					state_d       = F_DIV;
				end
			end
			F_EMIT: begin
				if (sts.out_free) begin
					cmd.out_load   = 1'b1;
					cmd.out_status = ST_FACTOR;
					cmd.take_p     = 1'b1;
					cmd.clr_e      = 1'b1;
					cmd.div_start  = 1'b1;
					state_d        = F_DIV;
				end
			end
			F_DIV: begin
				if (sts.div_done) begin
					state_d = F_CHK;
				end
			end
			F_CHK: begin
				if (!sts.x_one) begin
					state_d = F_RD;
				end else if (sts.out_free) begin
					cmd.out_load   = 1'b1;
					cmd.out_last   = 1'b1;
					cmd.out_status = ST_FACTOR;
					state_d        = S_IDLE;
				end
			end
			S_ONE: begin
				if (sts.out_free) begin
					cmd.out_load   = 1'b1;
					cmd.out_last   = 1'b1;
					cmd.out_status = res_st_q;
					state_d        = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// State registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			res_st_q <= ST_FACTOR;
			built_q  <= 1'b0;
		end else begin
			state_q  <= state_d;
			res_st_q <= res_st_d;
			built_q  <= built_d;
		end
	end

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for the smallest-prime-factor sieve and factorizer core.
`timescale 1ns / 1ps

module tb import spf_pkg::*; ();

	localparam logic MODE_BUILD  = 1'b0;
	localparam logic MODE_FACTOR = 1'b1;
	localparam int   MaxIdle     = 17;
	localparam int   RandomItems = 340;

	// One expected result of the factorizer.
	typedef struct {
		logic [ValueW-1:0] prime;
		logic [ExpW-1:0]   power;
		logic              last;
		status_t           status;
	} factor_res_t;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               s_tvalid;
	logic               s_tready;
	logic [ValueW-1:0]  s_tdata;
	logic               s_tuser;
	logic               m_tvalid;
	logic               m_tready;
	logic [DataW-1:0]   m_tdata;
	logic [StatusW-1:0] m_tuser;
	logic               m_tlast;

	// Predictor state and the store of results still to come.
	factor_res_t  pending_factors[$];
	factor_res_t  head;
	logic         table_ready;
	int unsigned  err_count;
	int unsigned  stall_left;
	int unsigned  hold_cycles;
	logic         send_idle;
	logic         recv_fast;
	int unsigned  smooth_primes[8] = '{2, 3, 5, 7, 11, 13, 17, 19};

	spf_sieve_factorizer_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),   // [15:0] value
		.s_tuser  (s_tuser),   // [0] mode
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),   // [15:0] prime, [20:16] exponent, [23:21] zero
		.m_tuser  (m_tuser),   // [1:0] status
		.m_tlast  (m_tlast)
	);

	always #10 clk = ~clk;

	task automatic log_error(input string msg);
		err_count++;
		if (err_count <= 10) begin
			$display("%0t ns: %s", $time, msg);
		end
	endtask

	function automatic void push_result(input int unsigned prime, input int unsigned power,
			input logic last, input status_t status);
		factor_res_t r;
		r.prime  = prime[ValueW-1:0];
		r.power  = power[ExpW-1:0];
		r.last   = last;
		r.status = status;
		pending_factors = {pending_factors, r};
	endfunction

	// Expected results of one accepted item, factored here by trial division.
	function automatic void predict_factors(input logic mode, input logic [ValueW-1:0] value);
		int unsigned rest;
		int unsigned p;
		int unsigned power;
		if (mode == MODE_BUILD) begin
			table_ready = 1'b1;
			push_result(0, 0, 1'b1, ST_BUILT);
		end else if (!table_ready || value == '0 || int'(value) >= TableSizeDef) begin
			push_result(0, 0, 1'b1, ST_INVALID);
		end else if (value == ValueW'(1)) begin
			push_result(0, 0, 1'b1, ST_ONE);
		end else begin
			rest = 32'(value);
			p = 2;
			while (rest > 1) begin
				// Past the square root, what remains is itself prime.
				if (p * p > rest)
					p = rest;
				if (rest % p == 0) begin
					power = 0;
					while (rest % p == 0) begin
						rest = rest / p;
						power++;
					end
					push_result(p, power, 1'b0, ST_FACTOR);
				end
				p++;
			end
			pending_factors[pending_factors.size()-1].last = 1'b1;
		end
	endfunction

	// Offer one item after a random gap (none while send_idle is set) and return at the edge that accepts it.
	task automatic send_item(input logic mode, input logic [ValueW-1:0] value);
		int unsigned gap;
		gap = send_idle ? 0 : $urandom_range(0, MaxIdle);
		@(negedge clk);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			s_tdata  <= ValueW'($urandom);
			s_tuser  <= 1'($urandom);
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= mode;
		s_tdata  <= value;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		predict_factors(mode, value);
	endtask

	task automatic drop_valid();
		@(negedge clk);
		s_tvalid <= 1'b0;
	endtask

	// Half the values have interesting structure, the other half are uniform.
	function automatic logic [ValueW-1:0] pick_value();
		int unsigned v;
		int unsigned p;
		case ($urandom_range(0, 9))
			0, 1: v = $urandom_range(0, 63);
			2, 3: begin
				v = 1;
				repeat ($urandom_range(1, 14)) begin
					p = smooth_primes[$urandom_range(0, 7)];
					if (v * p < TableSizeDef)
						v = v * p;
				end
			end
			4: v = $urandom_range(65000, 65535);
			default: v = $urandom_range(0, 65535);
		endcase
		return v[ValueW-1:0];
	endfunction

	// Factoring before any build must give the error result.
	task automatic test_unbuilt();
		send_item(MODE_FACTOR, 16'd0);
		send_item(MODE_FACTOR, 16'd1);
		send_item(MODE_FACTOR, 16'd12);
		send_item(MODE_FACTOR, 16'hFFFF);
	endtask

	// The value of a build item is ignored.
	task automatic test_build();
		send_item(MODE_BUILD, 16'hFFFF);
	endtask

	// Value one, zero, the largest prime, six distinct primes, high powers.
	task automatic test_corners();
		int unsigned corners[$] = '{0, 1, 2, 3, 4, 65535, 65521, 32768, 59049,
			30030, 60060, 65025, 49, 46189};
		foreach (corners[i])
			send_item(MODE_FACTOR, corners[i][ValueW-1:0]);
	endtask

	// The receiver holds off for a long stretch while items keep coming.
	task automatic test_backpressure();
		@(posedge clk);
		hold_cycles = 400;
		send_idle = 1'b1;
		repeat (10)
			send_item(MODE_FACTOR, pick_value());
		send_idle = 1'b0;
		drop_valid();
		wait (pending_factors.size() == 0);
	endtask

	// The sender waits for every result before it goes on.
	task automatic test_drain_pause();
		repeat (4)
			send_item(MODE_FACTOR, pick_value());
		drop_valid();
		wait (pending_factors.size() == 0);
		repeat (3)
			send_item(MODE_FACTOR, pick_value());
	endtask

	// Random items with one rebuild somewhere in the middle.
	task automatic test_random();
		int unsigned rebuild_at;
		rebuild_at = $urandom_range(20, RandomItems - 20);
		for (int i = 0; i < RandomItems; i++) begin
			// Change the idling pattern of both sides now and then.
			if (i % 40 == 0) begin
				send_idle = ($urandom_range(0, 3) == 0);
				recv_fast = ($urandom_range(0, 3) == 0);
			end
			if (i == rebuild_at)
				send_item(MODE_BUILD, ValueW'($urandom));
			else
				send_item(MODE_FACTOR, pick_value());
		end
		send_idle = 1'b0;
		recv_fast = 1'b0;
	endtask

	// Receiver: a long hold when asked, else a random stall after each result unless recv_fast is set.
	always @(negedge clk) begin
		if (hold_cycles > 0) begin
			m_tready <= 1'b0;
			hold_cycles--;
		end else if (stall_left > 0) begin
			m_tready <= 1'b0;
			stall_left--;
		end else begin
			m_tready <= 1'b1;
		end
	end

	// Compare each accepted result with the oldest expectation.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_factors.size() == 0) begin
				log_error($sformatf("result with none expected: tdata %h tuser %0d tlast %0b",
					m_tdata, m_tuser, m_tlast));
			end else begin
				head = pending_factors.pop_front();
				if (m_tdata[15:0] !== head.prime)
					log_error($sformatf("prime: expected %0d, got %0d", head.prime,
						m_tdata[15:0]));
				if (m_tdata[20:16] !== head.power)
					log_error($sformatf("exponent: expected %0d, got %0d", head.power,
						m_tdata[20:16]));
				if (m_tdata[23:21] !== 3'b000)
					log_error($sformatf("tdata padding: expected 0, got %0d", m_tdata[23:21]));
				if (m_tlast !== head.last)
					log_error($sformatf("last: expected %0b, got %0b", head.last, m_tlast));
				if (m_tuser !== head.status)
					log_error($sformatf("status: expected %0d, got %0d", head.status, m_tuser));
			end
			stall_left = recv_fast ? 0 : $urandom_range(0, MaxIdle);
		end
	end

	initial begin
		arst_n      = 1'b0;
		s_tvalid    = 1'b0;
		s_tdata     = '0;
		s_tuser     = MODE_BUILD;
		m_tready    = 1'b0;
		table_ready = 1'b0;
		err_count   = 0;
		stall_left  = 0;
		hold_cycles = 0;
		send_idle   = 1'b0;
		recv_fast   = 1'b0;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;

		test_unbuilt();
		test_build();
		test_corners();
		test_backpressure();
		test_drain_pause();
		test_random();

		// Let the last results come out, then watch for strays.
		drop_valid();
		wait (pending_factors.size() == 0);
		repeat (300) @(posedge clk);
		if (err_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	// Two full builds dominate; this leaves several times the slowest run.
	initial begin
		#100_000_000;
		$display("== FAIL ==");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/spf_pkg.sv
rtl/spf_div.sv
rtl/spf_dp.sv
rtl/spf_ctrl.sv
rtl/spf_sieve_factorizer_core.sv
tb/tb.sv
